FILE: src/dfrd_pkg.sv
package dfrd_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned FracW = 52;
  localparam int unsigned ExpW = 11;
  localparam logic [ExpW-1:0] ExpAllOnes = 11'h7ff;
  localparam logic [ExpW-1:0] ExpBias = 11'h3ff;
  localparam logic [WordW-1:0] QuietNan = 64'h7ff8_0000_0000_0000;
  localparam logic [WordW-1:0] MinusOne = 64'hbff0_0000_0000_0000;
  localparam logic [WordW-1:0] SignOnly = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_CONST,
    KIND_ROUND
  } kind_t;

  // Decoded operand as it leaves the first stage.
  typedef struct packed {
    logic [WordW-1:0] bits;
    logic [WordW-1:0] below;
    logic [WordW-1:0] unit;
    logic [WordW-1:0] konst;
    kind_t            kind;
  } dec_t;

  // Operand after the fraction test, as it leaves the second stage.
  typedef struct packed {
    logic [WordW-1:0] bits;
    logic [WordW-1:0] below;
    logic [WordW-1:0] addend;
    logic [WordW-1:0] konst;
    kind_t            kind;
  } chk_t;

endpackage

FILE: src/double_floor_round_down_top.sv
// Round-down (floor) unit for binary64 patterns: a new beat may enter every cycle unless the
// output stalls, and its result passes through the decode, check and round registers. The
// three stages decode the exponent and build the fraction mask, test the fraction bits,
// then add the carry unit and mask. A stall on the output freezes all stages together,
// so nothing is lost or repeated. NaN inputs give the quiet NaN 0x7FF8000000000000.
module double_floor_round_down_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand_bits [63:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // floor_bits [63:0]
);

  logic           en;
  logic           v1, v2;
  dfrd_pkg::dec_t dec;
  dfrd_pkg::chk_t chk;

  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  dfrd_decode u_decode (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(in_tvalid), .bits_in(in_tdata),
    .vld_r(v1), .dec_r(dec)
  );

  dfrd_check u_check (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v1), .dec_in(dec),
    .vld_r(v2), .chk_r(chk)
  );

  dfrd_round u_round (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(v2), .chk_in(chk),
    .vld_r(out_tvalid), .res_r(out_tdata)
  );

endmodule

FILE: src/dfrd_decode.sv
module dfrd_decode (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              vld_in,
  input  logic [dfrd_pkg::WordW-1:0]        bits_in,
  output logic                              vld_r,
  output dfrd_pkg::dec_t                    dec_r
);

  logic [dfrd_pkg::ExpW-1:0] exp_w;
  logic [dfrd_pkg::ExpW-1:0] unb_w;
  logic [5:0]                shift_w;
  dfrd_pkg::dec_t            dec_nxt;

  always_comb begin
    exp_w   = bits_in[dfrd_pkg::WordW-2:dfrd_pkg::FracW];
    unb_w   = exp_w - dfrd_pkg::ExpBias;
    shift_w = 6'(dfrd_pkg::FracW) - unb_w[5:0];
    dec_nxt.bits  = bits_in;
    dec_nxt.unit  = 64'd1 << shift_w;
    dec_nxt.below = dec_nxt.unit - 64'd1;
    dec_nxt.konst = '0;
    dec_nxt.kind  = dfrd_pkg::KIND_ROUND;
    if (exp_w == dfrd_pkg::ExpAllOnes) begin
      if (bits_in[dfrd_pkg::FracW-1:0] != '0) begin
        dec_nxt.kind  = dfrd_pkg::KIND_CONST;
        dec_nxt.konst = dfrd_pkg::QuietNan;
      end else begin
        dec_nxt.kind = dfrd_pkg::KIND_PASS;
      end
    end else if (exp_w < dfrd_pkg::ExpBias) begin
      dec_nxt.kind = dfrd_pkg::KIND_CONST;
      if (!bits_in[dfrd_pkg::WordW-1]) begin
        dec_nxt.konst = '0;
      end else if (bits_in[dfrd_pkg::WordW-2:0] != '0) begin
        dec_nxt.konst = dfrd_pkg::MinusOne;
      end else begin
        dec_nxt.konst = dfrd_pkg::SignOnly;
      end
    end else if (unb_w >= dfrd_pkg::ExpW'(dfrd_pkg::FracW)) begin
      dec_nxt.kind = dfrd_pkg::KIND_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

FILE: src/dfrd_check.sv
module dfrd_check (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_in,
  input  dfrd_pkg::dec_t dec_in,
  output logic           vld_r,
  output dfrd_pkg::chk_t chk_r
);

  dfrd_pkg::chk_t chk_nxt;

  always_comb begin
    chk_nxt.bits   = dec_in.bits;
    chk_nxt.below  = dec_in.below;
    chk_nxt.konst  = dec_in.konst;
    chk_nxt.kind   = dec_in.kind;
    chk_nxt.addend = dec_in.bits[dfrd_pkg::WordW-1] ? dec_in.unit : '0;
    if (dec_in.kind == dfrd_pkg::KIND_ROUND && (dec_in.bits & dec_in.below) == '0) begin
      chk_nxt.kind = dfrd_pkg::KIND_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      chk_r <= chk_nxt;
    end
  end

endmodule

FILE: src/dfrd_round.sv
module dfrd_round (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_in,
  input  dfrd_pkg::chk_t             chk_in,
  output logic                       vld_r,
  output logic [dfrd_pkg::WordW-1:0] res_r
);

  logic [dfrd_pkg::WordW-1:0] res_nxt;

  always_comb begin
    case (chk_in.kind)
      dfrd_pkg::KIND_PASS:  res_nxt = chk_in.bits;
      dfrd_pkg::KIND_CONST: res_nxt = chk_in.konst;
      dfrd_pkg::KIND_ROUND: res_nxt = (chk_in.bits + chk_in.addend) & ~chk_in.below;
      default:              res_nxt = chk_in.bits;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule
